[rtl/core/tccb_pkg.sv]
`default_nettype none
package tccb_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 128;
    localparam int unsigned MAX_ROWS_DEF    = 64;

    localparam int unsigned COL_W  = 7;
    localparam int unsigned ROW_W  = 6;
    localparam int unsigned LINE_W = 7;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned STEP_W = 4;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h00;
    localparam int unsigned TAB_STEP = 4;

    localparam logic [COL_W-1:0] LAST_COLUMN_RST = 7'd79;
    localparam logic [ROW_W-1:0] LAST_ROW_RST    = 6'd24;

    localparam logic [CFG_IDX_W-1:0] CFG_LAST_COLUMN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW    = 1'd1;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  target_column;
        logic [ROW_W-1:0]  target_row;
    } t_req;

    typedef struct packed {
        logic              cell_written;
        logic [COL_W-1:0]  write_column;
        logic [ROW_W-1:0]  write_row;
        logic [CHAR_W-1:0] write_char;
        logic              scrolled;
        logic [COL_W-1:0]  cursor_column;
        logic [LINE_W-1:0] cursor_row;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_CLEAR     = 4'd0;
    localparam t_step ST_IDLE      = 4'd1;
    localparam t_step ST_DECIDE    = 4'd2;
    localparam t_step ST_CP_CHK    = 4'd3;
    localparam t_step ST_CP_RD     = 4'd4;
    localparam t_step ST_CP_WR     = 4'd5;
    localparam t_step ST_CL_SET    = 4'd6;
    localparam t_step ST_CL_RUN    = 4'd7;
    localparam t_step ST_SCR_END   = 4'd8;
    localparam t_step ST_EXEC      = 4'd9;
    localparam t_step ST_EXEC_WAIT = 4'd10;

    typedef enum logic [1:0] {
        PTR_HOLD = 2'd0,
        PTR_ZERO = 2'd1,
        PTR_INC  = 2'd2
    } t_ptr_op;

    typedef enum logic [1:0] {
        END_HOLD  = 2'd0,
        END_COPY  = 2'd1,
        END_CLEAR = 2'd2
    } t_end_op;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_ZERO = 2'd1,
        WR_COPY = 2'd2
    } t_wr_sel;

    typedef enum logic [2:0] {
        C_NEXT       = 3'd0,
        C_ALWAYS     = 3'd1,
        C_NO_REQ     = 3'd2,
        C_NO_SCROLL  = 3'd3,
        C_PTR_AT_END = 3'd4,
        C_PTR_MORE   = 3'd5,
        C_OUT_FREE   = 3'd6
    } t_cond;

    typedef struct packed {
        logic    ready;
        logic    rd_en;
        t_wr_sel wr_sel;
        t_ptr_op ptr_op;
        t_end_op end_op;
        logic    scroll_set;
        logic    exec;
        t_cond   cond;
        t_step   target;
    } t_uword;

    typedef struct packed {
        logic req_valid;
        logic no_scroll;
        logic ptr_at_end;
        logic out_free;
    } t_stat;

    localparam t_uword UW_NOP = '{
        ready:      1'b0,
        rd_en:      1'b0,
        wr_sel:     WR_NONE,
        ptr_op:     PTR_HOLD,
        end_op:     END_HOLD,
        scroll_set: 1'b0,
        exec:       1'b0,
        cond:       C_NEXT,
        target:     ST_IDLE
    };

    function automatic t_uword urom(input t_step s);
        t_uword w;
        w = UW_NOP;
        case (s)
            ST_CLEAR: begin
                w.wr_sel = WR_ZERO;
                w.ptr_op = PTR_INC;
                w.cond   = C_PTR_MORE;
                w.target = ST_CLEAR;
            end
            ST_IDLE: begin
                w.ready  = 1'b1;
                w.cond   = C_NO_REQ;
                w.target = ST_IDLE;
            end
            ST_DECIDE: begin
                w.ptr_op = PTR_ZERO;
                w.end_op = END_COPY;
                w.cond   = C_NO_SCROLL;
                w.target = ST_EXEC;
            end
            ST_CP_CHK: begin
                w.cond   = C_PTR_AT_END;
                w.target = ST_CL_SET;
            end
            ST_CP_RD: begin
                w.rd_en = 1'b1;
            end
            ST_CP_WR: begin
                w.wr_sel = WR_COPY;
                w.ptr_op = PTR_INC;
                w.cond   = C_ALWAYS;
                w.target = ST_CP_CHK;
            end
            ST_CL_SET: begin
                w.end_op = END_CLEAR;
            end
            ST_CL_RUN: begin
                w.wr_sel = WR_ZERO;
                w.ptr_op = PTR_INC;
                w.cond   = C_PTR_MORE;
                w.target = ST_CL_RUN;
            end
            ST_SCR_END: begin
                w.scroll_set = 1'b1;
            end
            ST_EXEC: begin
                w.exec   = 1'b1;
                w.cond   = C_OUT_FREE;
                w.target = ST_IDLE;
            end
            ST_EXEC_WAIT: begin
                w.cond   = C_ALWAYS;
                w.target = ST_EXEC;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/core/tccb_chan_if.sv]
`default_nettype none
interface tccb_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/tccb_ram.sv]
`default_nettype none
module tccb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/tccb_seq.sv]
`default_nettype none
module tccb_seq
    import tccb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_stat  i_stat,
    output t_uword      o_uw
);
    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   take;

    always_comb begin
        uw = urom(r_step);
        case (uw.cond)
            C_NEXT:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_REQ:     take = !i_stat.req_valid;
            C_NO_SCROLL:  take = i_stat.no_scroll;
            C_PTR_AT_END: take = i_stat.ptr_at_end;
            C_PTR_MORE:   take = !i_stat.ptr_at_end;
            C_OUT_FREE:   take = i_stat.out_free;
            default:      take = 1'b0;
        endcase
        n_step = take ? uw.target : r_step + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uw = uw;
endmodule
`default_nettype wire

[rtl/core/tccb_datapath.sv]
`default_nettype none
module tccb_datapath
    import tccb_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_uword           i_uw,
    input  wire logic             i_req_valid,
    input  wire t_req             i_req,
    input  wire logic [COL_W-1:0] i_last_column,
    input  wire logic [ROW_W-1:0] i_last_row,
    input  wire logic             i_rsp_ready,
    output logic                  o_rsp_valid,
    output t_rsp                  o_rsp,
    output t_stat                 o_stat
);
    localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [7:0] COL_MAX = 8'(MAX_COLUMNS - 1);
    localparam logic [6:0] ROW_MAX = 7'(MAX_ROWS - 1);

    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     r_end;
    logic              r_cmd;
    logic [CHAR_W-1:0] r_ch;
    logic [COL_W-1:0]  r_tcol;
    logic [ROW_W-1:0]  r_trow;
    logic [COL_W-1:0]  r_col;
    logic [LINE_W-1:0] r_line;
    logic              r_scr;
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    logic [COL_W-1:0]  lc;
    logic [ROW_W-1:0]  lr;
    logic              accept;
    logic              out_free;
    logic              exec_fire;
    logic              is_nl;
    logic              is_cr;
    logic              is_tab;
    logic [7:0]        col_sum;
    logic              col_wrap;
    logic              ex_wr;
    logic [COL_W-1:0]  ex_wcol;
    logic [ROW_W-1:0]  ex_wrow;
    logic [AW-1:0]     ex_addr;
    logic [COL_W-1:0]  n_col;
    logic [LINE_W-1:0] n_line;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    assign lc = ({1'b0, i_last_column} > COL_MAX) ? COL_W'(COL_MAX) : i_last_column;
    assign lr = ({1'b0, i_last_row} > ROW_MAX) ? ROW_W'(ROW_MAX) : i_last_row;

    assign accept    = i_uw.ready && i_req_valid;
    assign out_free  = !r_rsp_valid || i_rsp_ready;
    assign exec_fire = i_uw.exec && out_free;

    always_comb begin
        is_nl    = (r_ch == CH_NEWLINE);
        is_cr    = (r_ch == CH_RETURN);
        is_tab   = (r_ch == CH_TAB);
        col_sum  = {1'b0, r_col} + (is_tab ? 8'(TAB_STEP) : 8'd1);
        col_wrap = col_sum > {1'b0, lc};
        n_col    = r_col;
        n_line   = r_line;
        ex_wr    = 1'b0;
        ex_wcol  = r_tcol;
        ex_wrow  = r_trow;
        if (r_cmd) begin
            ex_wr = (r_tcol <= lc) && (r_trow <= lr);
        end else begin
            ex_wcol = r_col;
            ex_wrow = ROW_W'(r_line);
            if (is_nl) begin
                n_col  = '0;
                n_line = r_line + LINE_W'(1);
            end else if (is_cr) begin
                n_col = '0;
            end else begin
                ex_wr = !is_tab && (r_col <= lc);
                if (col_wrap) begin
                    n_col  = '0;
                    n_line = r_line + LINE_W'(1);
                end else begin
                    n_col = col_sum[COL_W-1:0];
                end
            end
        end
        ex_addr = AW'(ex_wrow) * AW'(MAX_COLUMNS) + AW'(ex_wcol);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = CH_BLANK;
        case (i_uw.wr_sel)
            WR_ZERO: ram_we = 1'b1;
            WR_COPY: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            default: begin
                if (exec_fire && ex_wr) begin
                    ram_we    = 1'b1;
                    ram_waddr = ex_addr;
                    ram_wdata = r_ch;
                end
            end
        endcase
        ram_raddr = r_ptr + AW'(MAX_COLUMNS);
    end

    tccb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_uw.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_end       <= AW'(DEPTH - 1);
            r_col       <= '0;
            r_line      <= '0;
            r_scr       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            case (i_uw.ptr_op)
                PTR_ZERO: r_ptr <= '0;
                PTR_INC:  r_ptr <= r_ptr + AW'(1);
                default:  r_ptr <= r_ptr;
            endcase
            case (i_uw.end_op)
                END_COPY:  r_end <= AW'(lr) * AW'(MAX_COLUMNS);
                END_CLEAR: r_end <= r_end + AW'(MAX_COLUMNS - 1);
                default:   r_end <= r_end;
            endcase
            if (accept) begin
                r_scr <= 1'b0;
            end else if (i_uw.scroll_set) begin
                r_scr  <= 1'b1;
                r_line <= LINE_W'(lr);
            end
            if (exec_fire) begin
                r_col       <= n_col;
                r_line      <= n_line;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_req.command;
            r_ch   <= i_req.char_code;
            r_tcol <= i_req.target_column;
            r_trow <= i_req.target_row;
        end
        if (exec_fire) begin
            r_rsp.cell_written  <= ex_wr;
            r_rsp.write_column  <= ex_wr ? ex_wcol : '0;
            r_rsp.write_row     <= ex_wr ? ex_wrow : '0;
            r_rsp.write_char    <= ex_wr ? r_ch : CH_BLANK;
            r_rsp.scrolled      <= r_scr;
            r_rsp.cursor_column <= n_col;
            r_rsp.cursor_row    <= n_line;
        end
    end

    assign o_stat.req_valid  = i_req_valid;
    assign o_stat.no_scroll  = r_cmd || (r_line <= {1'b0, lr});
    assign o_stat.ptr_at_end = (r_ptr == r_end);
    assign o_stat.out_free   = out_free;

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
endmodule
`default_nettype wire

[rtl/core/text_console_cursor_buffer.sv]
// Each request runs through the micro-program's accept, decide and execute steps, plus any scroll, and
// no new request is taken meanwhile; execute waits while the last response has not been taken.
// A scroll copies rows 1 to last_row up one row, three steps per cell (check, read, write), through
// the single-port-pair character store, then clears the last row cell by cell.
// Reset: synchronous, active low; afterwards all MAX_COLUMNS * MAX_ROWS cells of the store are cleared
// one cell per cycle while no request is taken; configuration writes are always taken.
`default_nettype none
module text_console_cursor_buffer
    import tccb_pkg::*;
#(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tccb_chan_if.sink   i_req,
    tccb_chan_if.source o_rsp,
    tccb_chan_if.sink   i_cfg
);
    logic [COL_W-1:0] r_last_column;
    logic [ROW_W-1:0] r_last_row;
    t_uword           uw;
    t_stat            stat;
    t_cfg             cfg;

    assign cfg         = i_cfg.payload;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_column <= LAST_COLUMN_RST;
            r_last_row    <= LAST_ROW_RST;
        end else if (i_cfg.valid) begin
            case (cfg.index)
                CFG_LAST_COLUMN: r_last_column <= cfg.data[COL_W-1:0];
                CFG_LAST_ROW:    r_last_row    <= cfg.data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tccb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uw    (uw)
    );

    assign i_req.ready = uw.ready;

    tccb_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_uw          (uw),
        .i_req_valid   (i_req.valid),
        .i_req         (i_req.payload),
        .i_last_column (r_last_column),
        .i_last_row    (r_last_row),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_rsp         (o_rsp.payload),
        .o_stat        (stat)
    );
endmodule
`default_nettype wire

[bench/text_console_cursor_buffer_tb.sv]
`timescale 1ns / 100ps
module text_console_cursor_buffer_tb;
    import tccb_pkg::*;

    localparam logic CMD_PUT    = 1'b0;
    localparam logic CMD_PUT_AT = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 8000000;
    localparam int unsigned TAIL_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tccb_chan_if #(.t_payload(t_req)) req_if ();
    tccb_chan_if #(.t_payload(t_rsp)) rsp_if ();
    tccb_chan_if #(.t_payload(t_cfg)) cfg_if ();

    text_console_cursor_buffer uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if),
        .i_cfg  (cfg_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // console state as the block should hold it
    logic [COL_W-1:0] cfg_last_col = LAST_COLUMN_RST;
    logic [ROW_W-1:0] cfg_last_row = LAST_ROW_RST;
    int unsigned cur_col = 0;
    int unsigned cur_line = 0;

    t_rsp expected_cells[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    initial begin
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        rsp_if.ready   <= 1'b0;
    end

    function automatic t_rsp console_effect(input t_req r);
        t_rsp e;
        int unsigned lc;
        int unsigned lr;
        int unsigned col;
        int unsigned line;
        int unsigned step;
        int unsigned cfg_col;
        int unsigned cfg_row;
        e = '0;
        cfg_col = 32'(cfg_last_col);
        cfg_row = 32'(cfg_last_row);
        lc = (cfg_col > MAX_COLUMNS_DEF - 1) ? MAX_COLUMNS_DEF - 1 : cfg_col;
        lr = (cfg_row > MAX_ROWS_DEF - 1) ? MAX_ROWS_DEF - 1 : cfg_row;
        col = cur_col;
        line = cur_line;
        if (r.command == CMD_PUT_AT) begin
            if (32'(r.target_column) <= lc && 32'(r.target_row) <= lr) begin
                e.cell_written = 1'b1;
                e.write_column = r.target_column;
                e.write_row    = r.target_row;
                e.write_char   = r.char_code;
            end
        end else begin
            if (line > lr) begin
                line = lr;
                e.scrolled = 1'b1;
            end
            if (r.char_code == CH_NEWLINE) begin
                col = 0;
                line = line + 1;
            end else if (r.char_code == CH_RETURN) begin
                col = 0;
            end else begin
                step = 1;
                if (r.char_code == CH_TAB) begin
                    step = TAB_STEP;
                end else if (col <= lc) begin
                    e.cell_written = 1'b1;
                    e.write_column = col[COL_W-1:0];
                    e.write_row    = line[ROW_W-1:0];
                    e.write_char   = r.char_code;
                end
                col = col + step;
                if (col > lc) begin
                    col = 0;
                    line = line + 1;
                end
            end
        end
        cur_col = col & 32'h7F;
        cur_line = line & 32'h7F;
        e.cursor_column = cur_col[COL_W-1:0];
        e.cursor_row    = cur_line[LINE_W-1:0];
        return e;
    endfunction

    function automatic t_req cursor_req(input logic [CHAR_W-1:0] ch);
        t_req r;
        r.command       = CMD_PUT;
        r.char_code     = ch;
        r.target_column = COL_W'($urandom_range(0, 127));
        r.target_row    = ROW_W'($urandom_range(0, 63));
        return r;
    endfunction

    function automatic t_req cell_req(input int unsigned col, input int unsigned row,
                                      input logic [CHAR_W-1:0] ch);
        t_req r;
        r.command       = CMD_PUT_AT;
        r.char_code     = ch;
        r.target_column = col[COL_W-1:0];
        r.target_row    = row[ROW_W-1:0];
        return r;
    endfunction

    function automatic t_req random_req(input int unsigned lc, input int unsigned lr);
        t_req r;
        int unsigned pick;
        r = cursor_req(CHAR_W'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            r.command = CMD_PUT_AT;
            if ($urandom_range(0, 1) == 1) r.target_column = COL_W'($urandom_range(0, lc));
            if ($urandom_range(0, 1) == 1) r.target_row = ROW_W'($urandom_range(0, lr));
        end else if (pick < 25) begin
            r.char_code = CH_NEWLINE;
        end else if (pick < 30) begin
            r.char_code = CH_RETURN;
        end else if (pick < 38) begin
            r.char_code = CH_TAB;
        end else if (pick < 80) begin
            r.char_code = CHAR_W'($urandom_range(8'h20, 8'h7E));
        end
        return r;
    endfunction

    task automatic send_req(input t_req r);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.payload <= r;
        req_if.valid   <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        expected_cells.push_back(console_effect(r));
    endtask

    task automatic finish_phase();
        req_if.valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] col_data,
                              input logic [CFG_DATA_W-1:0] row_data);
        finish_phase();
        cfg_if.payload <= '{index: CFG_LAST_COLUMN, data: col_data};
        cfg_if.valid   <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_last_col = col_data;
        cfg_if.payload <= '{index: CFG_LAST_ROW, data: row_data};
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_last_row = row_data[ROW_W-1:0];
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    initial begin : check_responses
        int unsigned stall;
        t_rsp want;
        t_rsp got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            got = rsp_if.payload;
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got);
                error_count++;
            end else begin
                want = expected_cells.pop_front();
                check_field("cell_written", 32'(want.cell_written), 32'(got.cell_written));
                check_field("write_column", 32'(want.write_column), 32'(got.write_column));
                check_field("write_row", 32'(want.write_row), 32'(got.write_row));
                check_field("write_char", 32'(want.write_char), 32'(got.write_char));
                check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
                check_field("cursor_column", 32'(want.cursor_column),
                            32'(got.cursor_column));
                check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
            end
        end
    end

    initial begin : cycle_watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic test_default_screen();
        send_req(cursor_req(8'h41));
        send_req(cursor_req(CH_BLANK));
        send_req(cursor_req(8'hFF));
        send_req(cursor_req(CH_TAB));
        send_req(cursor_req(CH_RETURN));
        send_req(cursor_req(CH_NEWLINE));
        send_req(cell_req(79, 24, 8'h5A));
        send_req(cell_req(80, 24, 8'h5A));
        send_req(cell_req(79, 25, 8'h5A));
        send_req(cell_req(127, 63, 8'hFF));
        send_req(cell_req(0, 0, CH_NEWLINE));
    endtask

    // one cell per screen: every character and tab wraps, every later cursor put scrolls
    task automatic test_narrow_screen();
        set_config(7'd0, 7'd0);
        send_req(cursor_req(8'h61));
        send_req(cursor_req(8'h62));
        send_req(cursor_req(CH_TAB));
        send_req(cursor_req(CH_NEWLINE));
        send_req(cursor_req(CH_RETURN));
        send_req(cell_req(0, 0, 8'h80));
        send_req(cell_req(1, 0, 8'h80));
        send_req(cell_req(0, 1, 8'h80));
    endtask

    task automatic test_tab_wrap();
        set_config(7'd5, 7'd2);
        send_req(cursor_req(8'h78));
        send_req(cursor_req(CH_TAB));
        send_req(cursor_req(CH_TAB));
        send_req(cursor_req(8'h79));
        send_req(cursor_req(8'h79));
        send_req(cursor_req(8'h79));
        send_req(cursor_req(CH_TAB));
    endtask

    // leave the cursor outside a smaller screen, then shrink it
    task automatic test_shrink_screen();
        set_config(7'd127, 7'h48);
        send_req(cursor_req(CH_RETURN));
        repeat (3) send_req(cursor_req(CH_NEWLINE));
        repeat (30) send_req(cursor_req(CHAR_W'($urandom_range(8'h20, 8'h7E))));
        set_config(7'd10, 7'd1);
        send_req(cursor_req(8'h70));
        send_req(cell_req(11, 1, 8'h70));
        send_req(cursor_req(8'h71));
    endtask

    task automatic test_full_screen();
        set_config(7'd127, 7'h7F);
        send_req(cursor_req(CH_RETURN));
        while (cur_line < 63) send_req(cursor_req(CH_NEWLINE));
        repeat (31) send_req(cursor_req(CH_TAB));
        send_req(cursor_req(8'h61));
        send_req(cursor_req(8'h62));
        send_req(cursor_req(8'h63));
        send_req(cursor_req(8'h64));
        send_req(cursor_req(8'h65));
        send_req(cell_req(127, 63, 8'hFF));
    endtask

    task automatic test_random_text();
        int unsigned lc;
        int unsigned lr;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    lc = 127;
                    lr = 0;
                end
                1: begin
                    lc = 0;
                    lr = $urandom_range(0, 1);
                end
                default: begin
                    lc = $urandom_range(0, 127);
                    lr = (lc < 16) ? $urandom_range(0, 1) : $urandom_range(0, 4);
                end
            endcase
            set_config(7'(lc), {1'($urandom_range(0, 1)), 6'(lr)});
            for (int n = 0; n < 240; n++) begin
                if (n % 40 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                send_req(random_req(lc, lr));
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_screen();
        test_narrow_screen();
        test_tab_wrap();
        test_shrink_screen();
        test_full_screen();
        test_random_text();
        finish_phase();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
